### hw/rtl/ipt_pkg.sv
package ipt_pkg;

	// Field widths of the pulse and result words.
	localparam int PW_W    = 16;
	localparam int KEY_W   = 4;
	localparam int SCORE_W = 16;

	// Running difference sums saturate at the top of this width.
	localparam int SUM_W = 21;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// A sum must fall below this limit to count as a match.
	localparam logic [SUM_W-1:0] NO_MATCH_LIMIT = SUM_W'(16'hFFFF);

	// Default geometry of the template store.
	localparam int DEF_NUM_TEMPLATES = 10;
	localparam int DEF_TEMPLATE_LEN  = 25;

	// Built-in pulse templates, one row per key.
	localparam int BUILTIN_COUNT = 10;
	localparam int BUILTIN_LEN   = 25;

	localparam logic [PW_W-1:0] BUILTIN_TMPL [BUILTIN_COUNT][BUILTIN_LEN] = '{
		'{16'd2440, 16'd516, 16'd1232, 16'd541, 16'd616, 16'd541, 16'd615, 16'd542,
		  16'd1231, 16'd542, 16'd615, 16'd542, 16'd614, 16'd543, 16'd614, 16'd542,
		  16'd1230, 16'd543, 16'd615, 16'd542, 16'd613, 16'd543, 16'd614, 16'd543,
		  16'd614},
		'{16'd2440, 16'd515, 16'd640, 16'd517, 16'd615, 16'd541, 16'd615, 16'd541,
		  16'd616, 16'd542, 16'd615, 16'd542, 16'd615, 16'd541, 16'd614, 16'd542,
		  16'd1230, 16'd542, 16'd614, 16'd542, 16'd615, 16'd542, 16'd614, 16'd543,
		  16'd612},
		'{16'd2416, 16'd539, 16'd1231, 16'd541, 16'd615, 16'd541, 16'd614, 16'd542,
		  16'd614, 16'd543, 16'd614, 16'd542, 16'd614, 16'd542, 16'd613, 16'd543,
		  16'd1230, 16'd543, 16'd614, 16'd542, 16'd614, 16'd544, 16'd613, 16'd544,
		  16'd613},
		'{16'd2438, 16'd518, 16'd616, 16'd540, 16'd1231, 16'd541, 16'd615, 16'd541,
		  16'd615, 16'd541, 16'd615, 16'd542, 16'd615, 16'd542, 16'd615, 16'd541,
		  16'd1230, 16'd542, 16'd614, 16'd543, 16'd614, 16'd543, 16'd614, 16'd542,
		  16'd613},
		'{16'd2439, 16'd517, 16'd1232, 16'd541, 16'd1231, 16'd541, 16'd615, 16'd542,
		  16'd614, 16'd542, 16'd615, 16'd542, 16'd614, 16'd543, 16'd614, 16'd543,
		  16'd1229, 16'd543, 16'd614, 16'd543, 16'd614, 16'd543, 16'd614, 16'd543,
		  16'd614},
		'{16'd2416, 16'd540, 16'd616, 16'd541, 16'd616, 16'd541, 16'd1231, 16'd541,
		  16'd615, 16'd542, 16'd614, 16'd542, 16'd613, 16'd542, 16'd614, 16'd543,
		  16'd1231, 16'd542, 16'd614, 16'd543, 16'd615, 16'd542, 16'd614, 16'd543,
		  16'd613},
		'{16'd2416, 16'd540, 16'd1232, 16'd541, 16'd616, 16'd541, 16'd1231, 16'd541,
		  16'd615, 16'd542, 16'd615, 16'd542, 16'd614, 16'd542, 16'd615, 16'd543,
		  16'd1230, 16'd542, 16'd614, 16'd542, 16'd614, 16'd542, 16'd614, 16'd542,
		  16'd614},
		'{16'd2415, 16'd539, 16'd616, 16'd541, 16'd1231, 16'd541, 16'd1231, 16'd542,
		  16'd615, 16'd542, 16'd614, 16'd542, 16'd615, 16'd542, 16'd615, 16'd542,
		  16'd1230, 16'd542, 16'd614, 16'd543, 16'd614, 16'd542, 16'd615, 16'd542,
		  16'd614},
		'{16'd2440, 16'd516, 16'd1253, 16'd520, 16'd1231, 16'd541, 16'd1230, 16'd542,
		  16'd614, 16'd543, 16'd614, 16'd542, 16'd615, 16'd542, 16'd613, 16'd543,
		  16'd1230, 16'd543, 16'd614, 16'd543, 16'd614, 16'd543, 16'd613, 16'd544,
		  16'd613},
		'{16'd2417, 16'd538, 16'd616, 16'd541, 16'd616, 16'd541, 16'd615, 16'd542,
		  16'd1231, 16'd542, 16'd615, 16'd542, 16'd614, 16'd542, 16'd614, 16'd542,
		  16'd1231, 16'd542, 16'd614, 16'd542, 16'd615, 16'd542, 16'd614, 16'd543,
		  16'd614}
	};

	// Template entry lookup; entries outside the built-in set read as zero.
	function automatic logic [PW_W-1:0] tmpl_entry(input int unsigned t,
		input int unsigned p);
		logic [PW_W-1:0] val;
		val = '0;
		if (t < BUILTIN_COUNT && p < BUILTIN_LEN) begin
			val = BUILTIN_TMPL[t][p];
		end
		return val;
	endfunction

endpackage

### hw/rtl/ir_pulse_template_matcher.sv
// Channel  Direction  Handshake                   Payload
// pulse    in         pulse_valid / pulse_ready   pulse_width, last_pulse
// result   out        result_valid / result_ready match_found, matched_key, best_score
//
// One pulse word is accepted every cycle while the output is free or being taken.
// After its last pulse is accepted, a frame's result passes through the input register,
// the levels of the registered minimum tree and then the result register.
// Reset clears the running sums, the pulse position and all stage valid flags.
// A stall on the result side freezes every stage, and pulse_ready drops with it.
module ir_pulse_template_matcher #(
	parameter int NUM_TEMPLATES = ipt_pkg::DEF_NUM_TEMPLATES,
	parameter int TEMPLATE_LEN  = ipt_pkg::DEF_TEMPLATE_LEN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pulse_valid,
	output logic                        pulse_ready,
	input  logic [ipt_pkg::PW_W-1:0]    pulse_width,
	input  logic                        last_pulse,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        match_found,
	output logic [ipt_pkg::KEY_W-1:0]   matched_key,
	output logic [ipt_pkg::SCORE_W-1:0] best_score
);
	import ipt_pkg::*;

	localparam int POS_W = $clog2(TEMPLATE_LEN + 1);
	localparam int LVLS  = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 0;
	localparam int PAD   = 1 << LVLS;
	localparam int PKW   = (LVLS > 0) ? LVLS : 1;

	logic                 adv;
	logic                 vld_s1;
	logic [PW_W-1:0]      width_s1;
	logic                 last_s1;
	logic [POS_W-1:0]     pos_q;
	logic [SUM_W-1:0]     sums_q [NUM_TEMPLATES];
	logic [SUM_W-1:0]     nsum [NUM_TEMPLATES];
	logic                 pos_full;
	logic [SUM_W-1:0]     tsum_q [LVLS+1][PAD];
	logic [PKW-1:0]       tkey_q [LVLS+1][PAD];
	logic [LVLS:0]        tvld_q;
	logic                 found;
	logic                 res_vld_q;
	logic                 found_q;
	logic [KEY_W-1:0]     key_q;
	logic [SCORE_W-1:0]   score_q;

	// The whole pipeline moves whenever the result register can take a word.
	assign adv         = !res_vld_q || result_ready;
	assign pulse_ready = adv;
	assign pos_full    = (pos_q >= POS_W'(TEMPLATE_LEN));

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pulse_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pulse_valid) begin
			width_s1 <= pulse_width;
			last_s1  <= last_pulse;
		end
	end

	// Absolute difference against each template and saturating accumulate.
	always_comb begin
		logic [PW_W-1:0]  ref_w;
		logic [PW_W-1:0]  diff;
		logic [SUM_W:0]   acc;
		for (int t = 0; t < NUM_TEMPLATES; t++) begin
			ref_w = tmpl_entry(t, int'(pos_q));
			diff  = (width_s1 > ref_w) ? (width_s1 - ref_w) : (ref_w - width_s1);
			acc   = {1'b0, sums_q[t]} + (SUM_W + 1)'(diff);
			if (pos_full) begin
				nsum[t] = sums_q[t];
			end else if (acc[SUM_W]) begin
				nsum[t] = SUM_MAX;
			end else begin
				nsum[t] = acc[SUM_W-1:0];
			end
		end
	end

	// Running sums and pulse position; both clear after the last pulse of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int t = 0; t < NUM_TEMPLATES; t++) begin
				sums_q[t] <= '0;
			end
		end else if (adv && vld_s1) begin
			if (last_s1) begin
				pos_q <= '0;
				for (int t = 0; t < NUM_TEMPLATES; t++) begin
					sums_q[t] <= '0;
				end
			end else begin
				if (!pos_full) begin
					pos_q <= pos_q + POS_W'(1);
				end
				for (int t = 0; t < NUM_TEMPLATES; t++) begin
					sums_q[t] <= nsum[t];
				end
			end
		end
	end

	// Minimum tree valid flags, one per level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q <= '0;
		end else if (adv) begin
			tvld_q[0] <= vld_s1 && last_s1;
			for (int l = 0; l < LVLS; l++) begin
				tvld_q[l+1] <= tvld_q[l];
			end
		end
	end

	// Registered minimum tree; the left entry wins a tie, so the lower key wins.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < PAD; i++) begin
				tsum_q[0][i] <= (i < NUM_TEMPLATES) ? nsum[i] : SUM_MAX;
				tkey_q[0][i] <= PKW'(i);
			end
			for (int l = 0; l < LVLS; l++) begin
				for (int i = 0; i < PAD / 2; i++) begin
					if (i < (PAD >> (l + 1))) begin
						if (tsum_q[l][2*i+1] < tsum_q[l][2*i]) begin
							tsum_q[l+1][i] <= tsum_q[l][2*i+1];
							tkey_q[l+1][i] <= tkey_q[l][2*i+1];
						end else begin
							tsum_q[l+1][i] <= tsum_q[l][2*i];
							tkey_q[l+1][i] <= tkey_q[l][2*i];
						end
					end
				end
			end
		end
	end

	// Result register: match decision and score.
	assign found = (tsum_q[LVLS][0] < NO_MATCH_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= tvld_q[LVLS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tvld_q[LVLS]) begin
			found_q <= found;
			key_q   <= found ? KEY_W'(tkey_q[LVLS][0]) : '0;
			score_q <= found ? SCORE_W'(NO_MATCH_LIMIT - tsum_q[LVLS][0]) : '0;
		end
	end

	assign result_valid = res_vld_q;
	assign match_found  = found_q;
	assign matched_key  = key_q;
	assign best_score   = score_q;

	// A word without a match reports key and score as zero.
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !match_found) |-> (matched_key == '0 && best_score == '0))
		else $error("no-match word carries a nonzero key or score");

	// A match always leaves a positive score.
	a_match_score: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && match_found) |-> (best_score != '0))
		else $error("match reported with zero score");

	// The position restarts after the last pulse of a frame.
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s1 && last_s1) |=> (pos_q == '0))
		else $error("pulse position not cleared after frame end");

	// The position never runs past the template length.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(TEMPLATE_LEN))
		else $error("pulse position beyond template length");

endmodule
